// File: sv/bhv_pkg.sv
// Shared types and constants of the bitmap header validator.
package bhv_pkg;

  // Byte counter width and the common width used for length compares
  localparam int COUNT_BITS = 32;
  localparam int CMP_W      = (COUNT_BITS > 33) ? COUNT_BITS : 33;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Header capture window and payload magic window
  localparam int HDR_BYTES     = 54;
  localparam int HDR_IDX_W     = $clog2(HDR_BYTES);
  localparam int PAYLOAD_START = 14;
  localparam int MAGIC_BYTES   = 8;
  localparam int MAGIC_LANE_W  = $clog2(MAGIC_BYTES);

  // Job queue between capture and checker
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // Signature bytes
  localparam logic [7:0] SIG_B = 8'h42;
  localparam logic [7:0] SIG_M = 8'h4D;

  // Info header sizes
  localparam logic [31:0] INFO_V3 = 32'd40;
  localparam logic [31:0] INFO_V4 = 32'd108;
  localparam logic [31:0] INFO_V5 = 32'd124;

  // Compression codes
  localparam logic [31:0] COMP_RGB        = 32'd0;
  localparam logic [31:0] COMP_RLE8       = 32'd1;
  localparam logic [31:0] COMP_RLE4       = 32'd2;
  localparam logic [31:0] COMP_BITFIELDS  = 32'd3;
  localparam logic [31:0] COMP_JPEG       = 32'd4;
  localparam logic [31:0] COMP_PNG        = 32'd5;
  localparam logic [31:0] COMP_ABITFIELDS = 32'd6;

  // Embedded image magic
  localparam logic [15:0] JPEG_MAGIC    = 16'hD8FF;
  localparam logic [31:0] PNG_MAGIC_LO  = 32'h474E5089;
  localparam logic [31:0] PNG_MAGIC_HI  = 32'h0A1A0A0D;

  typedef logic [HDR_BYTES-1:0][7:0] hdr_t;

  // One input item
  typedef struct packed {
    logic [7:0] file_byte;
    logic       final_byte;
  } item_t;

  // One result item
  typedef struct packed {
    logic        header_ok;
    logic [31:0] image_end;
    logic [31:0] pixel_offset;
  } result_t;

  // Snapshot of one finished file, handed from capture to checker
  typedef struct packed {
    logic [COUNT_BITS-1:0] len;
    hdr_t                  hdr;
    logic [63:0]           magic;
  } job_t;

endpackage

// File: sv/bhv_front.sv
// Byte capture: counts file bytes, keeps the header and payload magic.
module bhv_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  bhv_pkg::item_t item,
  output logic           job_push,
  input  logic           job_full,
  output bhv_pkg::job_t  job
);
  import bhv_pkg::*;

  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] bytes_seen_next;
  logic                  count_saturated;
  hdr_t                  header_store;
  hdr_t                  header_store_next;
  logic [63:0]           payload_magic;
  logic [63:0]           payload_magic_next;

  logic                  accept;
  logic                  capture;
  logic                  wr_hdr;
  logic                  in_payload;
  logic [31:0]           offset;
  logic [CMP_W-1:0]      pos_x;
  logic [CMP_W-1:0]      off_x;
  logic [CMP_W-1:0]      delta;
  logic [MAGIC_LANE_W-1:0] lane;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign capture = accept && !count_saturated;

  // Locate the byte inside the header and the payload magic window
  assign offset     = {header_store[13], header_store[12], header_store[11], header_store[10]};
  assign pos_x      = CMP_W'(bytes_seen);
  assign off_x      = CMP_W'(offset);
  assign delta      = pos_x - off_x;
  assign lane       = delta[MAGIC_LANE_W-1:0];
  assign wr_hdr     = bytes_seen < COUNT_BITS'(HDR_BYTES);
  assign in_payload = (bytes_seen >= COUNT_BITS'(PAYLOAD_START)) && (pos_x >= off_x) &&
                      (delta < CMP_W'(MAGIC_BYTES));

  // Merge the current byte into header and magic
  always_comb begin
    header_store_next  = header_store;
    payload_magic_next = payload_magic;
    if (capture) begin
      for (int i = 0; i < HDR_BYTES; i++) begin
        if (wr_hdr && bytes_seen[HDR_IDX_W-1:0] == HDR_IDX_W'(i)) begin
          header_store_next[i] = item.file_byte;
        end
      end
      for (int k = 0; k < MAGIC_BYTES; k++) begin
        if (in_payload && lane == MAGIC_LANE_W'(k)) begin
          payload_magic_next[k*8 +: 8] = payload_magic[k*8 +: 8] | item.file_byte;
        end
      end
    end
  end

  // Saturating count, including the current byte
  assign bytes_seen_next = (bytes_seen != COUNT_MAX) ? bytes_seen + 1'b1 : bytes_seen;

  // Hand a snapshot to the checker on the final byte
  assign job_push  = accept && item.final_byte;
  assign job.len   = bytes_seen_next;
  assign job.hdr   = header_store_next;
  assign job.magic = payload_magic_next;

  // Hold header bytes until overwritten
  always_ff @(posedge clk) begin
    header_store <= header_store_next;
  end

  // Advance counter and magic; clear them after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen      <= '0;
      count_saturated <= 1'b0;
      payload_magic   <= '0;
    end else if (accept) begin
      if (item.final_byte) begin
        bytes_seen      <= '0;
        count_saturated <= 1'b0;
        payload_magic   <= '0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        payload_magic <= payload_magic_next;
        if (bytes_seen == COUNT_MAX) begin
          count_saturated <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/bhv_queue.sv
// Short job queue between byte capture and header checker.
module bhv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  bhv_pkg::job_t wdata,
  input  logic          pop,
  output logic          empty,
  output bhv_pkg::job_t rdata
);
  import bhv_pkg::*;

  job_t                  entries [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr;
  logic [JOBQ_PTR_W-1:0] rd_ptr;
  logic [JOBQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = count == JOBQ_CNT_W'(JOBQ_DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/bhv_back.sv
// Header checker: evaluates one captured file at a time through the idle, decode, measure and decide states.
module bhv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_empty,
  output logic             job_pop,
  input  bhv_pkg::job_t    job_in,
  output logic             empty,
  input  logic             pop,
  output bhv_pkg::result_t result
);
  import bhv_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MEASURE,
    ST_DECIDE
  } state_t;

  state_t      state;
  job_t        job;
  logic        out_valid;
  logic        result_load;

  // Decode stage registers
  logic        ok_a;
  logic        rgb_bf;
  logic        rle_emb;
  logic [11:0] need;
  logic [31:0] data;
  logic [31:0] size_image;
  logic [31:0] h_abs;
  logic [37:0] prod1;

  // Measure stage registers
  logic        ok_b;
  logic [63:0] prod2;

  // Decoded header fields
  logic [31:0] bf_size, off, bi_size, width, height, comp, clr_used, size_image_c;
  logic [15:0] res1, res2, planes, bits;
  logic [CMP_W-1:0] len_x;
  logic [7:0]  hsize;
  logic        rgb, rle8, rle4, bfields, embedded, known_bits, pal;
  logic [8:0]  max_colors, colors;
  logic [4:0]  masks;
  logic [31:0] data_c, h_abs_c;
  logic        ok_a_c, magic_ok;

  // Measure stage logic
  logic [38:0] prod1_rnd;
  logic [35:0] row;
  logic        row_ok, ok_b_c, ok_final;

  assign job_pop     = (state == ST_IDLE) && !job_empty;
  assign empty       = !out_valid;
  assign result_load = (state == ST_DECIDE) && (!out_valid || pop);

  // Pull little-endian fields from the header snapshot
  always_comb begin
    bf_size      = {job.hdr[5], job.hdr[4], job.hdr[3], job.hdr[2]};
    off          = {job.hdr[13], job.hdr[12], job.hdr[11], job.hdr[10]};
    res1         = {job.hdr[7], job.hdr[6]};
    res2         = {job.hdr[9], job.hdr[8]};
    bi_size      = {job.hdr[17], job.hdr[16], job.hdr[15], job.hdr[14]};
    width        = {job.hdr[21], job.hdr[20], job.hdr[19], job.hdr[18]};
    height       = {job.hdr[25], job.hdr[24], job.hdr[23], job.hdr[22]};
    planes       = {job.hdr[27], job.hdr[26]};
    bits         = {job.hdr[29], job.hdr[28]};
    comp         = {job.hdr[33], job.hdr[32], job.hdr[31], job.hdr[30]};
    size_image_c = {job.hdr[37], job.hdr[36], job.hdr[35], job.hdr[34]};
    clr_used     = {job.hdr[49], job.hdr[48], job.hdr[47], job.hdr[46]};
    len_x        = CMP_W'(job.len);
    hsize        = bi_size[7:0] + 8'd14;
  end

  // Classify compression and depth, size the palette and masks, check embedded magic
  always_comb begin
    rgb        = comp == COMP_RGB;
    rle8       = (comp == COMP_RLE8) && (bits == 16'd8);
    rle4       = (comp == COMP_RLE4) && (bits == 16'd4);
    bfields    = ((comp == COMP_BITFIELDS) || (comp == COMP_ABITFIELDS)) &&
                 ((bits == 16'd16) || (bits == 16'd32));
    embedded   = ((comp == COMP_JPEG) || (comp == COMP_PNG)) && (bits == 16'd0);
    known_bits = (bits == 16'd1) || (bits == 16'd4) || (bits == 16'd8) ||
                 (bits == 16'd16) || (bits == 16'd24) || (bits == 16'd32);
    pal        = (bits != 16'd0) && (bits <= 16'd8);
    max_colors = 9'd1 << bits[3:0];
    colors     = (clr_used == '0) ? max_colors : clr_used[8:0];
    masks      = '0;
    if ((bi_size == INFO_V3) && bfields) begin
      masks = (comp == COMP_ABITFIELDS) ? 5'd16 : 5'd12;
    end
    data_c  = bf_size - off;
    h_abs_c = height[31] ? (~height + 32'd1) : height;
    if (comp == COMP_JPEG) begin
      magic_ok = (data_c >= 32'd2) && (job.magic[15:0] == JPEG_MAGIC);
    end else begin
      magic_ok = (data_c >= 32'd8) && (job.magic[31:0] == PNG_MAGIC_LO) &&
                 (job.magic[63:32] == PNG_MAGIC_HI);
    end
  end

  // Structural checks on the header
  always_comb begin
    ok_a_c = (len_x >= CMP_W'(HDR_BYTES)) &&
             (job.hdr[0] == SIG_B) && (job.hdr[1] == SIG_M) &&
             ((bi_size == INFO_V3) || (bi_size == INFO_V4) || (bi_size == INFO_V5)) &&
             (CMP_W'(hsize) <= len_x) &&
             (bf_size >= 32'(hsize)) && (CMP_W'(bf_size) <= len_x) &&
             (off >= 32'(hsize)) && (off <= bf_size) &&
             (res1 == '0) && (res2 == '0) && (planes == 16'd1) &&
             !width[31] && (width != '0) && (height != '0) &&
             ((rgb && known_bits) || rle8 || rle4 || bfields || embedded) &&
             (!height[31] || rgb || bfields) &&
             (!pal || (clr_used == '0) || (clr_used <= 32'(max_colors))) &&
             (!embedded || magic_ok);
  end

  // Row stride from the registered width product, and the remaining bounds
  always_comb begin
    prod1_rnd = {1'b0, prod1} + 39'd31;
    row       = {prod1_rnd[38:5], 2'b00};
    row_ok    = (row != '0) && (h_abs != '0) && (row <= 36'(data));
    ok_b_c    = ok_a && (32'(need) <= off) && (size_image <= data) &&
                (rgb_bf ? row_ok : (!rle_emb || (size_image != '0)));
    ok_final  = ok_b && (!rgb_bf || (prod2 <= 64'(data)));
  end

  // Sequence one job through decode, measure and decide
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            job   <= job_in;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          ok_a       <= ok_a_c;
          rgb_bf     <= rgb || bfields;
          rle_emb    <= rle8 || rle4 || embedded;
          need       <= 12'(hsize) + 12'(masks) + (pal ? {1'b0, colors, 2'b00} : 12'd0);
          data       <= data_c;
          size_image <= size_image_c;
          h_abs      <= h_abs_c;
          prod1      <= width * bits[5:0];
          state      <= ST_MEASURE;
        end
        ST_MEASURE: begin
          ok_b  <= ok_b_c;
          prod2 <= row[31:0] * h_abs;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (result_load) begin
            result.header_ok    <= ok_final;
            result.image_end    <= ok_final ? bf_size : '0;
            result.pixel_offset <= ok_final ? off : '0;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/bitmap_header_validator.sv
// Top level of the bitmap header validator.
// Streams a BMP file in one byte per cycle while full is low (push/full) and returns one
// verdict item per file ending on the byte marked final (empty/pop): header_ok, and the
// declared file size and pixel-data offset when the header passes, zeros otherwise. Byte
// capture waits on the verdict only through the queue: each finished file is handed to a
// two-entry job queue, and the checker takes each file through load, decode with the
// width-times-depth product, row-times-height product and decide. full rises only when both
// entries are taken, as when short files arrive back to back or results are not popped.
module bitmap_header_validator (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  bhv_pkg::item_t   item,
  output logic             empty,
  input  logic             pop,
  output bhv_pkg::result_t result
);
  import bhv_pkg::*;

  job_t job_wdata;
  job_t job_rdata;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;

  // Capture bytes of the incoming file
  bhv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .job_push (job_push),
    .job_full (job_full),
    .job      (job_wdata)
  );

  // Buffer finished files for the checker
  bhv_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .full  (job_full),
    .wdata (job_wdata),
    .pop   (job_pop),
    .empty (job_empty),
    .rdata (job_rdata)
  );

  // Check headers and hold the verdict
  bhv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_in    (job_rdata),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
